/* rtl/core/mffr_pkg.sv */
// ----------------------------------------------------------------------------
// Motor feedback frame receiver package
// Shared constants, codes and word types of the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mffr_pkg;

    localparam int FRAME_LEN  = 10;
    localparam int DATA_BYTES = FRAME_LEN - 1;
    localparam int POS_W      = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_CRC     = 3'd1;
    localparam logic [2:0] ST_FAULT   = 3'd2;
    localparam logic [2:0] ST_ID      = 3'd3;
    localparam logic [2:0] ST_TIMEOUT = 3'd4;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic [7:0] target_id;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         motor_mode;
        logic signed [15:0] current_raw;
        logic signed [15:0] velocity_raw;
        logic [15:0]        position_raw;
        logic [7:0]         fault_flags;
    } t_out_word;

    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/mffr_if.sv */
// ----------------------------------------------------------------------------
// Frame receiver channel interfaces
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mffr_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;
    logic [7:0] target_id;

    modport source (output valid, output req_type, output rx_byte,
                    output target_id, input ready);
    modport sink   (input valid, input req_type, input rx_byte,
                    input target_id, output ready);
endinterface

interface mffr_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [7:0]         motor_mode;
    logic signed [15:0] current_raw;
    logic signed [15:0] velocity_raw;
    logic [15:0]        position_raw;
    logic [7:0]         fault_flags;

    modport source (output valid, output status, output motor_mode,
                    output current_raw, output velocity_raw,
                    output position_raw, output fault_flags, input ready);
    modport sink   (input valid, input status, input motor_mode,
                    input current_raw, input velocity_raw,
                    input position_raw, input fault_flags, output ready);
endinterface

`default_nettype wire

/* rtl/core/mffr_crc8.sv */
// ----------------------------------------------------------------------------
// Reflected CRC-8 byte update
// Advances a Maxim CRC-8 by one byte, bits taken LSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module mffr_crc8
    import mffr_pkg::*;
(
    input  wire logic [7:0] i_crc,
    input  wire logic [7:0] i_data,
    output logic      [7:0] o_crc
);

    always_comb begin
        logic [7:0] crc;
        logic [7:0] data;
        crc  = i_crc;
        data = i_data;
        for (int k = 0; k < 8; k++) begin
            if (crc[0] ^ data[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
            data = data >> 1;
        end
        o_crc = crc;
    end

endmodule

`default_nettype wire

/* rtl/core/mffr_assembler.sv */
// ----------------------------------------------------------------------------
// Frame assembler
// Holds byte position, running CRC and captured bytes; forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mffr_assembler
    import mffr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire t_in_word i_word,
    output t_result       o_result
);

    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_crc;
    logic [7:0]       r_id;
    logic [7:0]       r_bytes [DATA_BYTES];

    logic [POS_W-1:0] n_pos;
    logic [7:0]       n_crc;
    logic [7:0]       n_id;
    logic [7:0]       crc_upd;
    logic             is_timeout;
    logic             is_check;

    mffr_crc8 u_crc8 (
        .i_crc  (r_crc),
        .i_data (i_word.rx_byte),
        .o_crc  (crc_upd)
    );

    assign is_timeout = (i_word.req_type == REQ_TIMEOUT);
    assign is_check   = (r_pos >= LAST_POS);

    always_comb begin
        o_result       = '0;
        o_result.valid = is_timeout || is_check;
        if (is_timeout) begin
            o_result.word.status = ST_TIMEOUT;
        end else if (r_crc != i_word.rx_byte) begin
            o_result.word.status = ST_CRC;
        end else begin
            if (r_bytes[8] != 8'd0) begin
                o_result.word.status = ST_FAULT;
            end else if (r_bytes[0] != r_id) begin
                o_result.word.status = ST_ID;
            end else begin
                o_result.word.status = ST_OK;
            end
            o_result.word.motor_mode   = r_bytes[1];
            o_result.word.current_raw  = {r_bytes[2], r_bytes[3]};
            o_result.word.velocity_raw = {r_bytes[4], r_bytes[5]};
            o_result.word.position_raw = {r_bytes[6], r_bytes[7]};
            o_result.word.fault_flags  = r_bytes[8];
        end
    end

    always_comb begin
        n_pos = r_pos;
        n_crc = r_crc;
        n_id  = r_id;
        if (is_timeout || is_check) begin
            n_pos = '0;
            n_crc = '0;
        end else begin
            if (r_pos == '0) begin
                n_id = i_word.target_id;
            end
            n_crc = crc_upd;
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= '0;
            r_id  <= '0;
        end else if (i_en) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
            r_id  <= n_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && !is_timeout && !is_check) begin
            for (int i = 0; i < DATA_BYTES; i++) begin
                if (r_pos == POS_W'(i)) begin
                    r_bytes[i] <= i_word.rx_byte;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/motor_feedback_frame_receiver.sv */
// ----------------------------------------------------------------------------
// Motor feedback frame receiver
// Assembles 10-byte feedback frames, checks CRC-8, emits one status word.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   word
//  i_rx     in   req_type, rx_byte, target_id              one byte or timeout
//  o_res    out  status, mode, current, velocity,          one per frame end
//                position, fault_flags                     or timeout
//
//  One word per cycle while the result is not stalled; a word passes the input register, then the result register.
//  Bytes 0 to 8 give no result; byte 9 or a timeout gives one.
//  Reset clears byte position, CRC, addressed id and both valid flags.
//  A stalled result holds; the input register still fills behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_feedback_frame_receiver
    import mffr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mffr_in_if.sink   i_rx,
    mffr_out_if.source o_res
);

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;

    logic      adv;
    logic      asm_en;
    t_result   asm_res;

    assign adv        = !r_out_valid || o_res.ready;
    assign i_rx.ready = !r_in_valid || adv;
    assign asm_en     = r_in_valid && adv;

    mffr_assembler u_assembler (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (asm_en),
        .i_word   (r_in),
        .o_result (asm_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (adv) begin
                r_out_valid <= asm_en && asm_res.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready) begin
            r_in.req_type  <= i_rx.req_type;
            r_in.rx_byte   <= i_rx.rx_byte;
            r_in.target_id <= i_rx.target_id;
        end
        if (adv) begin
            r_out <= asm_res.word;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out.status;
    assign o_res.motor_mode   = r_out.motor_mode;
    assign o_res.current_raw  = r_out.current_raw;
    assign o_res.velocity_raw = r_out.velocity_raw;
    assign o_res.position_raw = r_out.position_raw;
    assign o_res.fault_flags  = r_out.fault_flags;

    a_out_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a buffered input word");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_rx.ready)
        else $error("input stalled while result register empty");

    a_blank_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == ST_TIMEOUT || r_out.status == ST_CRC))
        |-> (r_out.motor_mode == 8'd0 && r_out.current_raw == 16'sd0 &&
             r_out.velocity_raw == 16'sd0 && r_out.position_raw == 16'd0 &&
             r_out.fault_flags == 8'd0))
        else $error("timeout or crc result carries frame fields");

endmodule

`default_nettype wire
